### hdl/nfci_pkg.sv
// Shared types and constants of the NOR flash command interface.
package nfci_pkg;

    // Sizing
    localparam int ADDR_BITS   = 20;
    localparam int SECTOR_BITS = 16;
    localparam int ADDR_W      = 20;   // width of the byte address field
    localparam int ADDR_USED   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int WADDR_W     = ADDR_USED - 1;
    localparam int WORDS       = 1 << WADDR_W;
    localparam int SEC_W       = (SECTOR_BITS < ADDR_USED) ? (SECTOR_BITS - 1) : WADDR_W;
    localparam logic [WADDR_W-1:0] SEC_MASK  = WADDR_W'((64'd1 << SEC_W) - 64'd1);
    localparam logic [WADDR_W-1:0] FULL_MASK = '1;

    localparam int DATA_W    = 16;
    localparam int PTICKS_W  = 16;
    localparam int ETICKS_W  = 24;
    localparam int CODE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // Bus protocol constants
    localparam logic [11:0] UNLOCK_ADDR_1   = 12'h0AAA;
    localparam logic [11:0] UNLOCK_ADDR_2   = 12'h0554;
    localparam logic [7:0]  DATA_UNLOCK_1   = 8'hAA;
    localparam logic [7:0]  DATA_UNLOCK_2   = 8'h55;
    localparam logic [7:0]  OP_AUTOSELECT   = 8'h90;
    localparam logic [7:0]  OP_PROGRAM      = 8'hA0;
    localparam logic [7:0]  OP_RESET        = 8'hF0;
    localparam logic [7:0]  OP_ERASE_SETUP  = 8'h80;
    localparam logic [7:0]  OP_SECTOR_ERASE = 8'h30;
    localparam logic [DATA_W-1:0] ERASED_WORD = 16'hFFFF;

    // Register reset values
    localparam logic [PTICKS_W-1:0] PROGRAM_TICKS_RST = 16'd8;
    localparam logic [ETICKS_W-1:0] ERASE_TICKS_RST   = 24'd1024;
    localparam logic [CODE_W-1:0]   MFR_CODE_RST      = 8'h20;
    localparam logic [CODE_W-1:0]   DEV_CODE_RST      = 8'hE9;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROGRAM_TICKS = 2'd0,
        CFG_ERASE_TICKS   = 2'd1,
        CFG_MFR_CODE      = 2'd2,
        CFG_DEV_CODE      = 2'd3
    } t_cfg_idx;

    // Unlock/command sequence position
    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_UNL1     = 3'd1,
        SEQ_UNL2     = 3'd2,
        SEQ_PROG     = 3'd3,
        SEQ_ERS      = 3'd4,
        SEQ_ERS_UNL1 = 3'd5,
        SEQ_ERS_UNL2 = 3'd6
    } t_seq;

    // Control sequencer
    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_READ,
        CTL_PROG,
        CTL_ERASE,
        CTL_DONE
    } t_ctl;

    // Word store access
    typedef struct packed {
        logic               re;
        logic               we;
        logic [WADDR_W-1:0] addr;
        logic [DATA_W-1:0]  wdata;
    } t_ram_req;

endpackage

### hdl/nfci_in_if.sv
// Bus access channel: one read, write, tick or no-op per word.
interface nfci_in_if import nfci_pkg::*;;
    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

### hdl/nfci_out_if.sv
// Result channel: one word per accepted access.
interface nfci_out_if import nfci_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              busy_res;
    logic              rejected;

    modport source (output valid, read_data, busy_res, rejected, input ready);
    modport sink   (input valid, read_data, busy_res, rejected, output ready);
endinterface

### hdl/nfci_cfg_if.sv
// Configuration write channel.
interface nfci_cfg_if import nfci_pkg::*;;
    logic                 valid;
    logic                 ready;
    t_cfg_idx             index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/nfci_word_ram.sv
// Single-port word store with registered read data.
module nfci_word_ram import nfci_pkg::*; (
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nor_flash_command_interface.sv
// Top level of the NOR flash command interface model.
//
// Behaves as a 16-bit NOR flash with the usual unlock command set: AA at 0xAAA,
// 55 at 0x554, then A0 (program next word, old AND new), 80 + unlock + 30
// (sector erase to FFFF), 90 (autoselect IDs at word 0 and 1) or F0 (reset).
// Each word on the access channel is a bus read, bus write, time tick or no-op
// and gives exactly one result word. Accesses are handled one at a time; the
// array sits in a single-port word store with registered read data. An array
// read passes through READ, a program through PROG, a sector erase through ERASE
// before DONE; all else goes to DONE, which loads the result register when free.
// A sector erase sweeps its 2^(SECTOR_BITS-1)-word sector (32768 as built) one
// word per cycle before the result is produced; busy time counts from then on
// in ticks. After reset all 2^(ADDR_BITS-1) words (524288 as built) are swept
// to FFFF while no access is accepted; configuration writes are taken at all
// times. A result waiting on the output does not stop the next access being
// taken: one further result is held back.
module nor_flash_command_interface import nfci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nfci_in_if.sink     i_cmd,
    nfci_out_if.source  o_res,
    nfci_cfg_if.sink    i_cfg
);

    // Control state
    t_ctl                r_state, n_state;
    t_seq                r_seq, n_seq;
    logic                r_auto, n_auto;
    logic [ETICKS_W-1:0] r_busy, n_busy;
    logic                r_toggle, n_toggle;
    logic [WADDR_W-1:0]  r_sweep, n_sweep;
    logic [WADDR_W-1:0]  r_mask, n_mask;
    logic                r_out_valid, n_out_valid;

    // Configuration
    logic [PTICKS_W-1:0] r_prog_ticks;
    logic [ETICKS_W-1:0] r_erase_ticks;
    logic [CODE_W-1:0]   r_mfr_code;
    logic [CODE_W-1:0]   r_dev_code;

    // Payload
    logic [WADDR_W-1:0] r_widx, n_widx;
    logic [DATA_W-1:0]  r_wdata, n_wdata;
    logic [DATA_W-1:0]  r_res_rd, n_res_rd;
    logic               r_res_rej, n_res_rej;
    logic [DATA_W-1:0]  r_out_rd, n_out_rd;
    logic               r_out_busy, n_out_busy;
    logic               r_out_rej, n_out_rej;

    t_ram_req          w_ram_req;
    logic [DATA_W-1:0] w_ram_q;

    logic               w_accept;
    logic               w_busy;
    logic [WADDR_W-1:0] w_widx;
    logic [7:0]         w_code;
    logic               w_at_a1;
    logic               w_at_a2;
    logic               w_wr_ok;
    logic               w_go_read;
    logic               w_go_prog;
    logic               w_go_erase;
    logic               w_sweep_last;
    logic [WADDR_W-1:0] w_sweep_addr;
    logic               w_out_free;

    nfci_word_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_q)
    );

    // Decode of the incoming access
    assign i_cmd.ready = (r_state == CTL_IDLE);
    assign w_accept    = i_cmd.valid && (r_state == CTL_IDLE);
    assign w_busy      = (r_busy != '0);
    assign w_widx      = i_cmd.address[ADDR_USED-1:1];
    assign w_code      = i_cmd.write_data[7:0];
    // unlock addresses compare on bits 11..1 only
    assign w_at_a1     = (i_cmd.address[11:1] == UNLOCK_ADDR_1[11:1]);
    assign w_at_a2     = (i_cmd.address[11:1] == UNLOCK_ADDR_2[11:1]);
    assign w_wr_ok     = (i_cmd.command == CMD_WRITE) && !w_busy;
    assign w_go_read   = (i_cmd.command == CMD_READ) && !w_busy && !r_auto;
    assign w_go_prog   = w_wr_ok && (r_seq == SEQ_PROG);
    assign w_go_erase  = w_wr_ok && (r_seq == SEQ_ERS_UNL2) && (w_code == OP_SECTOR_ERASE);

    // Sweep addressing: clear pass uses the full mask, erase the sector mask
    assign w_sweep_addr = (r_widx & ~r_mask) | (r_sweep & r_mask);
    assign w_sweep_last = ((r_sweep & r_mask) == r_mask);

    assign w_out_free = !r_out_valid || o_res.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CTL_CLEAR: begin
                if (w_sweep_last) n_state = CTL_IDLE;
            end
            CTL_IDLE: begin
                if (w_accept) begin
                    if (w_go_read)       n_state = CTL_READ;
                    else if (w_go_prog)  n_state = CTL_PROG;
                    else if (w_go_erase) n_state = CTL_ERASE;
                    else                 n_state = CTL_DONE;
                end
            end
            CTL_READ:  n_state = CTL_DONE;
            CTL_PROG:  n_state = CTL_DONE;
            CTL_ERASE: begin
                if (w_sweep_last) n_state = CTL_DONE;
            end
            CTL_DONE: begin
                if (w_out_free) n_state = CTL_IDLE;
            end
            default:   n_state = CTL_IDLE;
        endcase
    end

    // Datapath, store access and sequence decoding
    always_comb begin
        n_seq       = r_seq;
        n_auto      = r_auto;
        n_busy      = r_busy;
        n_toggle    = r_toggle;
        n_sweep     = r_sweep;
        n_mask      = r_mask;
        n_widx      = r_widx;
        n_wdata     = r_wdata;
        n_res_rd    = r_res_rd;
        n_res_rej   = r_res_rej;
        n_out_rd    = r_out_rd;
        n_out_busy  = r_out_busy;
        n_out_rej   = r_out_rej;
        n_out_valid = r_out_valid && !o_res.ready;
        w_ram_req   = '0;

        unique case (r_state)
            CTL_CLEAR: begin
                w_ram_req.we    = 1'b1;
                w_ram_req.addr  = w_sweep_addr;
                w_ram_req.wdata = ERASED_WORD;
                n_sweep         = r_sweep + 1'b1;
            end
            CTL_IDLE: begin
                if (w_accept) begin
                    n_widx    = w_widx;
                    n_wdata   = i_cmd.write_data;
                    n_res_rd  = '0;
                    n_res_rej = 1'b0;
                    case (i_cmd.command)
                        CMD_READ: begin
                            if (w_busy) begin
                                // status poll: bit 6 toggles per read
                                n_toggle = ~r_toggle;
                                n_res_rd = {9'b0, ~r_toggle, 6'b0};
                            end else if (r_auto) begin
                                if (w_widx == WADDR_W'(0))
                                    n_res_rd = {8'b0, r_mfr_code};
                                else if (w_widx == WADDR_W'(1))
                                    n_res_rd = {8'b0, r_dev_code};
                            end else begin
                                w_ram_req.re   = 1'b1;
                                w_ram_req.addr = w_widx;
                            end
                        end
                        CMD_WRITE: begin
                            if (w_busy) begin
                                n_res_rej = 1'b1;
                            end else if (r_seq == SEQ_PROG) begin
                                w_ram_req.re   = 1'b1;
                                w_ram_req.addr = w_widx;
                                n_seq          = SEQ_IDLE;
                            end else if (w_code == OP_RESET) begin
                                n_auto = 1'b0;
                                n_seq  = SEQ_IDLE;
                            end else begin
                                n_seq = SEQ_IDLE;
                                unique case (r_seq)
                                    SEQ_IDLE: begin
                                        if (w_code == DATA_UNLOCK_1 && w_at_a1) n_seq = SEQ_UNL1;
                                    end
                                    SEQ_UNL1: begin
                                        if (w_code == DATA_UNLOCK_2 && w_at_a2) n_seq = SEQ_UNL2;
                                    end
                                    SEQ_UNL2: begin
                                        if (w_at_a1) begin
                                            if (w_code == OP_PROGRAM)          n_seq  = SEQ_PROG;
                                            else if (w_code == OP_ERASE_SETUP) n_seq  = SEQ_ERS;
                                            else if (w_code == OP_AUTOSELECT)  n_auto = 1'b1;
                                        end
                                    end
                                    SEQ_ERS: begin
                                        if (w_code == DATA_UNLOCK_1 && w_at_a1)
                                            n_seq = SEQ_ERS_UNL1;
                                    end
                                    SEQ_ERS_UNL1: begin
                                        if (w_code == DATA_UNLOCK_2 && w_at_a2)
                                            n_seq = SEQ_ERS_UNL2;
                                    end
                                    SEQ_ERS_UNL2: begin
                                        if (w_code == OP_SECTOR_ERASE) begin
                                            n_sweep = '0;
                                            n_mask  = SEC_MASK;
                                        end
                                    end
                                    default: n_seq = SEQ_IDLE;
                                endcase
                            end
                        end
                        CMD_TICK: begin
                            if (w_busy) n_busy = r_busy - 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            CTL_READ: begin
                n_res_rd = w_ram_q;
            end
            CTL_PROG: begin
                // program can only clear bits
                w_ram_req.we    = 1'b1;
                w_ram_req.addr  = r_widx;
                w_ram_req.wdata = w_ram_q & r_wdata;
                n_busy          = {{(ETICKS_W-PTICKS_W){1'b0}}, r_prog_ticks};
            end
            CTL_ERASE: begin
                w_ram_req.we    = 1'b1;
                w_ram_req.addr  = w_sweep_addr;
                w_ram_req.wdata = ERASED_WORD;
                n_sweep         = r_sweep + 1'b1;
                if (w_sweep_last) n_busy = r_erase_ticks;
            end
            CTL_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_res_rd;
                    n_out_busy  = w_busy;
                    n_out_rej   = r_res_rej;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CTL_CLEAR;
            r_seq       <= SEQ_IDLE;
            r_auto      <= 1'b0;
            r_busy      <= '0;
            r_toggle    <= 1'b0;
            r_sweep     <= '0;
            r_mask      <= FULL_MASK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seq       <= n_seq;
            r_auto      <= n_auto;
            r_busy      <= n_busy;
            r_toggle    <= n_toggle;
            r_sweep     <= n_sweep;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_ticks  <= PROGRAM_TICKS_RST;
            r_erase_ticks <= ERASE_TICKS_RST;
            r_mfr_code    <= MFR_CODE_RST;
            r_dev_code    <= DEV_CODE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PROGRAM_TICKS: r_prog_ticks  <= i_cfg.data[PTICKS_W-1:0];
                CFG_ERASE_TICKS:   r_erase_ticks <= i_cfg.data[ETICKS_W-1:0];
                CFG_MFR_CODE:      r_mfr_code    <= i_cfg.data[CODE_W-1:0];
                CFG_DEV_CODE:      r_dev_code    <= i_cfg.data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_widx     <= n_widx;
        r_wdata    <= n_wdata;
        r_res_rd   <= n_res_rd;
        r_res_rej  <= n_res_rej;
        r_out_rd   <= n_out_rd;
        r_out_busy <= n_out_busy;
        r_out_rej  <= n_out_rej;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.read_data = r_out_rd;
    assign o_res.busy_res  = r_out_busy;
    assign o_res.rejected  = r_out_rej;

endmodule

### verif/nfci_response_check.sv
// Result checker for the NOR flash command interface: tracks chip state, compares result words.
`timescale 1ns / 1ps
module nfci_response_check import nfci_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    nfci_in_if   i_cmd,
    nfci_out_if  i_res,
    nfci_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_due
);

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              busy_res;
        logic              rejected;
    } t_response;

    // Chip state as the bus sees it
    logic [DATA_W-1:0]   array_words [WORDS];
    t_seq                seq;
    logic                autosel;
    logic [ETICKS_W-1:0] busy_left;
    logic                toggle;

    logic [PTICKS_W-1:0] program_len;
    logic [ETICKS_W-1:0] erase_len;
    logic [CODE_W-1:0]   mfr_code;
    logic [CODE_W-1:0]   dev_code;

    t_response responses_due [$];
    int        errors = 0;

    // Unlock and command addresses only decode bits 11..1
    function automatic logic hits(logic [ADDR_W-1:0] a, logic [11:0] target);
        return a[11:1] == target[11:1];
    endfunction

    function automatic void take_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        logic [WADDR_W-1:0] widx;
        logic [WADDR_W-1:0] base;
        logic [7:0]         code;
        t_seq               was;
        int                 i;
        widx = a[ADDR_USED-1:1];
        code = d[7:0];
        was  = seq;
        if (was == SEQ_PROG) begin
            array_words[widx] &= d;
            busy_left = ETICKS_W'(program_len);
            seq = SEQ_IDLE;
            return;
        end
        if (code == OP_RESET) begin
            autosel = 1'b0;
            seq = SEQ_IDLE;
            return;
        end
        seq = SEQ_IDLE;
        case (was)
            SEQ_IDLE: begin
                if (code == DATA_UNLOCK_1 && hits(a, UNLOCK_ADDR_1)) seq = SEQ_UNL1;
            end
            SEQ_UNL1: begin
                if (code == DATA_UNLOCK_2 && hits(a, UNLOCK_ADDR_2)) seq = SEQ_UNL2;
            end
            SEQ_UNL2: begin
                if (hits(a, UNLOCK_ADDR_1)) begin
                    if (code == OP_PROGRAM) seq = SEQ_PROG;
                    else if (code == OP_ERASE_SETUP) seq = SEQ_ERS;
                    else if (code == OP_AUTOSELECT) autosel = 1'b1;
                end
            end
            SEQ_ERS: begin
                if (code == DATA_UNLOCK_1 && hits(a, UNLOCK_ADDR_1)) seq = SEQ_ERS_UNL1;
            end
            SEQ_ERS_UNL1: begin
                if (code == DATA_UNLOCK_2 && hits(a, UNLOCK_ADDR_2)) seq = SEQ_ERS_UNL2;
            end
            SEQ_ERS_UNL2: begin
                if (code == OP_SECTOR_ERASE) begin
                    base = widx & ~SEC_MASK;
                    for (i = 0; i <= int'(SEC_MASK); i++)
                        array_words[base | WADDR_W'(i)] = ERASED_WORD;
                    busy_left = erase_len;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_response flash_response(t_cmd c, logic [ADDR_W-1:0] a,
                                                 logic [DATA_W-1:0] d);
        t_response          r;
        logic [WADDR_W-1:0] widx;
        r    = '0;
        widx = a[ADDR_USED-1:1];
        case (c)
            CMD_READ: begin
                if (busy_left != 0) begin
                    toggle = ~toggle;
                    r.read_data = {9'd0, toggle, 6'd0};
                end else if (autosel) begin
                    if (widx == 0) r.read_data = {8'd0, mfr_code};
                    else if (widx == 1) r.read_data = {8'd0, dev_code};
                end else begin
                    r.read_data = array_words[widx];
                end
            end
            CMD_WRITE: begin
                if (busy_left != 0) r.rejected = 1'b1;
                else take_write(a, d);
            end
            CMD_TICK: begin
                if (busy_left != 0) busy_left--;
            end
            default: ;
        endcase
        r.busy_res = (busy_left != 0);
        return r;
    endfunction

    task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_response want;
        if (!i_rst_n) begin
            foreach (array_words[i]) array_words[i] = ERASED_WORD;
            seq         = SEQ_IDLE;
            autosel     = 1'b0;
            busy_left   = '0;
            toggle      = 1'b0;
            program_len = PROGRAM_TICKS_RST;
            erase_len   = ERASE_TICKS_RST;
            mfr_code    = MFR_CODE_RST;
            dev_code    = DEV_CODE_RST;
            responses_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_PROGRAM_TICKS: program_len = i_cfg.data[PTICKS_W-1:0];
                    CFG_ERASE_TICKS:   erase_len   = i_cfg.data[ETICKS_W-1:0];
                    CFG_MFR_CODE:      mfr_code    = i_cfg.data[CODE_W-1:0];
                    CFG_DEV_CODE:      dev_code    = i_cfg.data[CODE_W-1:0];
                    default: ;
                endcase
            end
            // result first, so a stray word is not matched to this cycle's access
            if (i_res.valid && i_res.ready) begin
                if (responses_due.size() == 0) begin
                    $display("%0t ns: result word %h/%b/%b with no access outstanding",
                             $time, i_res.read_data, i_res.busy_res, i_res.rejected);
                    errors++;
                end else begin
                    want = responses_due.pop_front();
                    check_field("read_data", want.read_data, i_res.read_data);
                    check_field("busy_res", DATA_W'(want.busy_res), DATA_W'(i_res.busy_res));
                    check_field("rejected", DATA_W'(want.rejected), DATA_W'(i_res.rejected));
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                responses_due.push_back(flash_response(i_cmd.command, i_cmd.address,
                                                       i_cmd.write_data));
        end
        o_due    <= responses_due.size();
        o_errors <= errors;
    end

endmodule

### verif/nor_flash_command_interface_test.sv
// Top of the NOR flash command interface regression: clock, reset, bus traffic and verdict.
`timescale 1ns / 1ps
module nor_flash_command_interface_test import nfci_pkg::*;;

    // Enough for the clearing pass, six sector sweeps and all the traffic,
    // several times over, before we call it hung.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int LONG_HOLD   = 600;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nfci_in_if  acc_bus ();
    nfci_out_if res_bus ();
    nfci_cfg_if cfg_bus ();

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int words_sent    = 0;
    int erases_left   = 0;
    int cycles        = 0;
    int fail_count;
    int due_count;

    // long receiver hold-off: top flips hold_req, the sink process does the counting
    bit hold_req  = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    nor_flash_command_interface dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (acc_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    nfci_response_check response_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (acc_bus),
        .i_res    (res_bus),
        .i_cfg    (cfg_bus),
        .o_errors (fail_count),
        .o_due    (due_count)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("nor_flash_command_interface regression: fail");
            $finish;
        end
    end

    // Result receiver: random back-pressure, plus one long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Offer one access word; valid stays high on return so back-to-back words
    // never see valid dropped and raised in the same step.
    task automatic send(t_cmd c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            acc_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        acc_bus.valid      <= 1'b1;
        acc_bus.command    <= c;
        acc_bus.address    <= a;
        acc_bus.write_data <= d;
        @(posedge i_clk);
        while (!acc_bus.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic wr(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        send(CMD_WRITE, a, d);
    endtask

    task automatic rd(logic [ADDR_W-1:0] a);
        send(CMD_READ, a, DATA_W'($urandom));
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [PTICKS_W-1:0] prog, logic [ETICKS_W-1:0] ers,
                            logic [CODE_W-1:0] mfr, logic [CODE_W-1:0] dev);
        put_reg(CFG_PROGRAM_TICKS, CFG_DAT_W'(prog));
        put_reg(CFG_ERASE_TICKS, CFG_DAT_W'(ers));
        put_reg(CFG_MFR_CODE, CFG_DAT_W'(mfr));
        put_reg(CFG_DEV_CODE, CFG_DAT_W'(dev));
        cfg_bus.valid <= 1'b0;
    endtask

    // Drop valid and wait until every result word is back. The first edge lets
    // the checker's count catch up with the word just accepted.
    task automatic wait_quiet();
        acc_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Decoded address with junk in the ignored bits (above 11 and bit 0)
    function automatic logic [ADDR_W-1:0] near(logic [11:0] target);
        logic [31:0] r;
        r = $urandom;
        return {r[7:0], target[11:1], r[8]};
    endfunction

    // Command code with junk in the ignored high byte
    function automatic logic [DATA_W-1:0] code_word(logic [7:0] code);
        logic [7:0] hi;
        hi = 8'($urandom);
        return {hi, code};
    endfunction

    // Mostly a few words in four sectors, so programs and erases get read back
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [31:0] r;
        logic [3:0]  sec;
        r = $urandom;
        if (r[31:30] == 2'b00) return r[ADDR_W-1:0];
        case (r[29:28])
            2'd0:    sec = 4'h0;
            2'd1:    sec = 4'h5;
            2'd2:    sec = 4'h9;
            default: sec = 4'hF;
        endcase
        return {sec, 11'd0, r[4:0]};
    endfunction

    task automatic unlock();
        wr(near(UNLOCK_ADDR_1), code_word(DATA_UNLOCK_1));
        wr(near(UNLOCK_ADDR_2), code_word(DATA_UNLOCK_2));
    endtask

    // One lone word: read, tick or unused code, with random fields
    task automatic stray_word();
        int k;
        k = $urandom_range(9);
        if (k < 5) rd(pick_addr());
        else if (k < 9) send(CMD_TICK, ADDR_W'($urandom), DATA_W'($urandom));
        else send(CMD_NOP, ADDR_W'($urandom), DATA_W'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // Directed opening: extremes, every command, the corner cases
    // (expects program_ticks 2, erase_ticks 1, IDs 00/FF)
    // ---------------------------------------------------------------------
    task automatic directed_words();
        rd(20'hFFFFF);                                      // top word, erased by clearing pass
        // program: ignored address bits set, data high byte set
        wr({8'hFF, UNLOCK_ADDR_1[11:1], 1'b1}, {8'hFF, DATA_UNLOCK_1});
        wr({8'h00, UNLOCK_ADDR_2}, {8'h00, DATA_UNLOCK_2});
        wr({8'h00, UNLOCK_ADDR_1}, {8'h00, OP_PROGRAM});
        wr(20'hFFFFF, {8'h00, OP_RESET});                   // F0 as program data programs it
        rd(20'h00000);                                      // busy: status toggles
        wr(20'h00000, 16'h1234);                            // busy: rejected
        send(CMD_TICK, 20'h00000, 16'h0000);
        send(CMD_TICK, 20'hFFFFF, 16'hFFFF);                // busy ends here
        rd(20'hFFFFE);
        // autoselect: IDs at words 0 and 1, zero elsewhere, F0 leaves
        unlock();
        wr({8'h00, UNLOCK_ADDR_1}, {8'h00, OP_AUTOSELECT});
        rd(20'h00000);
        rd(20'h00003);
        rd(20'h00004);
        wr(20'h12345, {8'hAB, OP_RESET});
        // sector erase of the top sector
        unlock();
        wr({8'h00, UNLOCK_ADDR_1}, {8'h00, OP_ERASE_SETUP});
        unlock();
        wr(20'hFFFFE, {8'h00, OP_SECTOR_ERASE});
        send(CMD_TICK, 20'h00000, 16'h0000);
        rd(20'hFFFFE);
        // broken unlock: second unlock write one word off
        wr({8'h00, UNLOCK_ADDR_1}, {8'h00, DATA_UNLOCK_1});
        wr({8'h00, UNLOCK_ADDR_2 + 12'd2}, {8'h00, DATA_UNLOCK_2});
        send(CMD_NOP, 20'hFFFFF, 16'hFFFF);
    endtask

    // ---------------------------------------------------------------------
    // Random traffic: well-formed command sequences with random content, lone words
    // (the most common draw), broken sequences and noise writes.
    // Sector erases cost a full sweep each, so they come from a small budget.
    // ---------------------------------------------------------------------
    task automatic random_traffic(int count);
        int                target;
        int                k;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        target = words_sent + count;
        while (words_sent < target) begin
            k = $urandom_range(99);
            if (k < 28) begin
                // word program, sometimes with a lone word before the data word
                unlock();
                wr(near(UNLOCK_ADDR_1), code_word(OP_PROGRAM));
                if ($urandom_range(7) == 0) stray_word();
                a = pick_addr();
                wr(a, DATA_W'($urandom));
                if ($urandom_range(1) == 1) rd(a);
            end else if (k < 33) begin
                unlock();
                wr(near(UNLOCK_ADDR_1), code_word(OP_ERASE_SETUP));
                unlock();
                if (erases_left > 0) begin
                    erases_left--;
                    wr(pick_addr(), code_word(OP_SECTOR_ERASE));
                end else begin
                    // out of budget: finish the sequence with anything but the erase code
                    d = DATA_W'($urandom);
                    if (d[7:0] == OP_SECTOR_ERASE) d[7:0] = OP_RESET;
                    wr(pick_addr(), d);
                end
            end else if (k < 40) begin
                unlock();
                wr(near(UNLOCK_ADDR_1), code_word(OP_AUTOSELECT));
                repeat ($urandom_range(4, 1)) rd(ADDR_W'($urandom_range(7)));
                if ($urandom_range(9) < 7) wr(ADDR_W'($urandom), code_word(OP_RESET));
            end else if (k < 46) begin
                // broken sequences: unlock at the wrong address, command at the wrong address
                wr(near(UNLOCK_ADDR_1), code_word(DATA_UNLOCK_1));
                if ($urandom_range(1) == 0) begin
                    wr(near(UNLOCK_ADDR_1), code_word(DATA_UNLOCK_2));
                end else begin
                    wr(near(UNLOCK_ADDR_2), code_word(DATA_UNLOCK_2));
                    wr(near(UNLOCK_ADDR_2), code_word(OP_PROGRAM));
                end
            end else if (k < 92) begin
                stray_word();
            end else begin
                wr(ADDR_W'($urandom), DATA_W'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Run
    // ---------------------------------------------------------------------
    initial begin
        acc_bus.valid      <= 1'b0;
        acc_bus.command    <= CMD_READ;
        acc_bus.address    <= '0;
        acc_bus.write_data <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_PROGRAM_TICKS;
        cfg_bus.data       <= '0;
        i_rst_n            <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles 16 %, receiver 79 %. The first access waits out the
        // clearing pass on its own handshake.
        src_idle_pct  = 16;
        sink_idle_pct = 79;
        set_regs(16'd2, 24'd1, 8'h00, 8'hFF);
        directed_words();
        wait_quiet();

        // Programs leave the chip not busy at all with a zero tick count
        erases_left = 1;
        set_regs(16'd0, 24'd17, 8'hFF, 8'h00);
        random_traffic(500);
        wait_quiet();

        // Roles swapped; the long hold lands mid-phase and fills the block
        src_idle_pct  = 79;
        sink_idle_pct = 16;
        erases_left   = 2;
        set_regs(16'd1, 24'd5, 8'($urandom), 8'($urandom));
        random_traffic(250);
        hold_req = ~hold_req;
        random_traffic(250);
        wait_quiet();

        // No idling either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        erases_left   = 1;
        set_regs(16'd9, 24'd40, 8'($urandom), 8'($urandom));
        random_traffic(500);
        // tick out any busy time so the final erase is taken
        repeat (64) send(CMD_TICK, ADDR_W'($urandom), DATA_W'($urandom));
        wait_quiet();

        // Largest tick counts: erase, then traffic against a chip that stays busy
        erases_left = 0;
        set_regs(16'hFFFF, 24'hFFFFFF, 8'($urandom), 8'($urandom));
        unlock();
        wr(near(UNLOCK_ADDR_1), code_word(OP_ERASE_SETUP));
        unlock();
        wr(pick_addr(), code_word(OP_SECTOR_ERASE));
        random_traffic(100);
        wait_quiet();

        if (fail_count == 0) begin
            $display("nor_flash_command_interface regression: pass");
        end else begin
            $display("nor_flash_command_interface regression: fail");
        end
        $finish;
    end

endmodule

### files.f
hdl/nfci_pkg.sv
hdl/nfci_in_if.sv
hdl/nfci_out_if.sv
hdl/nfci_cfg_if.sv
hdl/nfci_word_ram.sv
hdl/nor_flash_command_interface.sv
verif/nfci_response_check.sv
verif/nor_flash_command_interface_test.sv
